// File: rtl/ecfr_pkg.sv
// Shared types, constants and the byte-wide CRC function of the escaped CRC frame receiver.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ecfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1024;
    localparam int unsigned FIFO_DEPTH      = 4;

    localparam int unsigned MAXLEN_W  = 11;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned LEN_W     = 11;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [10:0] MAX_LENGTH_RST   = 11'd1024;
    localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd5000;

    localparam logic [7:0]  SYNC_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 1'd1;

    // Input beat kinds.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // End-of-frame status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRAME    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRC      = 3'd4;

    // A classified line beat, as passed from the front end to the frame engine.
    typedef struct packed {
        logic       is_idle;
        logic       is_sync;
        logic       is_esc;
        logic [7:0] raw;
        logic [7:0] unesc;
    } t_token;

    typedef struct packed {
        logic                kind;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] status;
        logic [7:0]          frame_type;
        logic [LEN_W-1:0]    frame_length;
    } t_result;

    // CRC-16/CCITT-FALSE update over one byte, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/ecfr_front.sv
// Front end of the escaped CRC frame receiver: accepts line beats and classifies them.
// Depends on ecfr_pkg; feeds ecfr_fifo.
module ecfr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [7:0]                  i_byte,
    output logic                        o_push,
    output ecfr_pkg::t_token            o_token,
    input  logic                        i_full
);

    logic             r_valid;
    logic             n_valid;
    ecfr_pkg::t_token r_token;
    ecfr_pkg::t_token n_token;
    logic             accept;

    // The holding register frees itself whenever the queue takes its beat.
    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_token = r_token;

    always_comb begin
        n_token.is_idle = (i_cmd == ecfr_pkg::CMD_IDLE);
        n_token.is_sync = (i_byte == ecfr_pkg::SYNC_BYTE);
        n_token.is_esc  = (i_byte == ecfr_pkg::ESC_BYTE);
        n_token.raw     = i_byte;
        n_token.unesc   = i_byte ^ ecfr_pkg::ESC_XOR;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_token <= n_token;
        end
    end

endmodule

// File: rtl/ecfr_fifo.sv
// Short token queue between the front end and the frame engine of the receiver.
// Depends on ecfr_pkg for the token type.
module ecfr_fifo #(
    parameter int unsigned DEPTH = ecfr_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ecfr_pkg::t_token i_token,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ecfr_pkg::t_token o_token
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ecfr_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

// File: rtl/ecfr_back.sv
// Frame engine of the receiver: phase sequencer, CRC, timeout and the result register.
// Depends on ecfr_pkg; takes tokens from ecfr_fifo.
module ecfr_back #(
    parameter int unsigned MAX_PAYLOAD = ecfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ecfr_pkg::MAXLEN_W-1:0]     i_max_length,
    input  logic [ecfr_pkg::TIMEOUT_W-1:0]    i_byte_timeout,
    input  logic                              i_tok_valid,
    input  ecfr_pkg::t_token                  i_token,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output ecfr_pkg::t_result                 o_result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_LO  = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;
    localparam logic [2:0] PH_CRC_HI  = 3'd6;

    localparam logic [15:0] PAYLOAD_LIMIT = 16'(MAX_PAYLOAD);

    logic [2:0]                   r_phase, n_phase;
    logic                         r_esc, n_esc;
    logic [7:0]                   r_len_lo, n_len_lo;
    logic [ecfr_pkg::LEN_W-1:0]   r_len, n_len;
    logic [ecfr_pkg::LEN_W-1:0]   r_cnt, n_cnt;
    logic [15:0]                  r_crc, n_crc;
    logic [7:0]                   r_crc_lo, n_crc_lo;
    logic [7:0]                   r_type, n_type;
    logic [15:0]                  r_idle, n_idle;
    logic                         r_out_valid, n_out_valid;
    ecfr_pkg::t_result            r_out, n_out;

    logic                         step;
    logic                         emit;
    ecfr_pkg::t_result            res;
    logic                         data_ok;
    logic [7:0]                   d;
    logic [15:0]                  len_full;
    logic [15:0]                  limit;
    logic [15:0]                  idle_inc;
    logic [15:0]                  crc_next;
    logic [ecfr_pkg::LEN_W-1:0]   cnt_inc;

    // The engine moves one token whenever the result register is free or being emptied.
    assign step     = i_tok_valid && (!r_out_valid || i_ready);
    assign o_pop    = step;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign len_full = {d, r_len_lo};
    assign limit    = (i_byte_timeout == '0) ? 16'd1 : i_byte_timeout;
    assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign crc_next = ecfr_pkg::crc_byte(r_crc, d);
    assign cnt_inc  = r_cnt + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_type   = r_type;
        n_idle   = r_idle;
        emit     = 1'b0;
        data_ok  = 1'b0;
        d        = i_token.raw;
        res      = '0;

        if (i_token.is_idle) begin
            if (r_phase != PH_HUNT) begin
                n_idle = idle_inc;
                if (idle_inc >= limit) begin
                    emit       = 1'b1;
                    res.kind   = ecfr_pkg::KIND_STATUS;
                    res.status = ecfr_pkg::ST_TIMEOUT;
                end
            end
        end else if (r_phase == PH_HUNT) begin
            if (i_token.is_sync) begin
                n_phase  = PH_LEN_LO;
                n_esc    = 1'b0;
                n_len_lo = '0;
                n_len    = '0;
                n_cnt    = '0;
                n_crc    = ecfr_pkg::CRC_INIT;
                n_crc_lo = '0;
                n_type   = '0;
                n_idle   = '0;
            end
        end else begin
            n_idle = '0;
            if (r_esc) begin
                n_esc   = 1'b0;
                d       = i_token.unesc;
                data_ok = 1'b1;
            end else if (i_token.is_sync) begin
                emit       = 1'b1;
                res.kind   = ecfr_pkg::KIND_STATUS;
                res.status = ecfr_pkg::ST_FRAME;
            end else if (i_token.is_esc) begin
                n_esc = 1'b1;
            end else begin
                data_ok = 1'b1;
            end
        end

        if (data_ok) begin
            unique case (r_phase)
                PH_LEN_LO: begin
                    n_len_lo = d;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len_full > {5'd0, i_max_length} || len_full > PAYLOAD_LIMIT) begin
                        emit       = 1'b1;
                        res.kind   = ecfr_pkg::KIND_STATUS;
                        res.status = ecfr_pkg::ST_OVERFLOW;
                    end else begin
                        n_len   = len_full[ecfr_pkg::LEN_W-1:0];
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type  = d;
                    n_crc   = crc_next;
                    n_cnt   = '0;
                    n_phase = (r_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc = crc_next;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                    emit             = 1'b1;
                    res.kind         = ecfr_pkg::KIND_PAYLOAD;
                    res.payload_byte = d;
                end
                PH_CRC_LO: begin
                    n_crc_lo = d;
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    emit           = 1'b1;
                    res.kind       = ecfr_pkg::KIND_STATUS;
                    res.frame_type = r_type;
                    if ({d, r_crc_lo} == r_crc) begin
                        res.status       = ecfr_pkg::ST_OK;
                        res.frame_length = r_len;
                    end else begin
                        res.status = ecfr_pkg::ST_CRC;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_esc   = 1'b0;
                end
            endcase
        end

        // Every end of frame, good or bad, goes back to hunting.
        if (emit && res.kind == ecfr_pkg::KIND_STATUS) begin
            n_phase = PH_HUNT;
            n_esc   = 1'b0;
            n_idle  = '0;
        end

        if (step) begin
            n_out_valid = emit;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        n_out = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_esc       <= 1'b0;
            r_len_lo    <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_crc       <= ecfr_pkg::CRC_INIT;
            r_crc_lo    <= '0;
            r_type      <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (step) begin
                r_phase  <= n_phase;
                r_esc    <= n_esc;
                r_len_lo <= n_len_lo;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_crc    <= n_crc;
                r_crc_lo <= n_crc_lo;
                r_type   <= n_type;
                r_idle   <= n_idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/escaped_crc_frame_receiver_top.sv
// Top level of the escaped CRC frame receiver: configuration registers and the
// front end, token queue and frame engine. Depends on ecfr_pkg and all ecfr_* modules.
//
// Usage. The slave stream carries one beat per line event: tuser is the command
// (0 = a byte arrived, carried in tdata[7:0]; 1 = one idle tick). The master stream
// returns zero or one beat per input beat: tuser 0 is a decoded payload byte in
// tdata[7:0]; tuser 1 is the end-of-frame status with the type and length beside it.
// Frames open with a raw 0x7E, use 0x7D escapes, and carry a little-endian length,
// a type byte, the payload and a little-endian CRC-16/CCITT-FALSE over type and
// payload. Any status returns the receiver to hunting for the next sync byte.
//
// Throughput is one beat per cycle while the master side does not stall: the frame
// engine computes a byte-wide CRC update and one phase step combinationally per token.
// A result passes through the front end's holding register and the token queue,
// after which the frame engine loads it into its result register.
// When the master side stalls, the frame engine stops, the four-entry token queue
// fills and then the slave side deasserts tready; no beat is lost.
// Reset is synchronous and active low; it empties the queue and the result
// register, sets hunting, and loads max_length = 1024 and byte_timeout = 5000.
// Configuration writes take effect on the next cycle and are meant for idle times.
module escaped_crc_frame_receiver_top #(
    parameter int unsigned MAX_PAYLOAD = ecfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Slave side (received line events).
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [ecfr_pkg::IN_DATA_W-1:0]       i_s_tdata,   // [7:0] rx_byte
    input  logic                                 i_s_tuser,   // [0] command
    // Master side (decoded bytes and frame status).
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [ecfr_pkg::OUT_DATA_W-1:0]      o_m_tdata,   // [7:0] payload_byte,
                                                              // [10:8] status,
                                                              // [18:11] frame_type,
                                                              // [29:19] frame_length,
                                                              // [31:30] zero
    output logic                                 o_m_tuser,   // [0] kind
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [ecfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ecfr_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [ecfr_pkg::MAXLEN_W-1:0]  r_max_length;
    logic [ecfr_pkg::TIMEOUT_W-1:0] r_byte_timeout;

    logic              push;
    logic              full;
    logic              pop;
    logic              tok_valid;
    ecfr_pkg::t_token  front_token;
    ecfr_pkg::t_token  queue_token;
    ecfr_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length   <= ecfr_pkg::MAX_LENGTH_RST;
            r_byte_timeout <= ecfr_pkg::BYTE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ecfr_pkg::REG_MAX_LENGTH:
                    r_max_length <= i_cfg_data[ecfr_pkg::MAXLEN_W-1:0];
                ecfr_pkg::REG_BYTE_TIMEOUT:
                    r_byte_timeout <= i_cfg_data[ecfr_pkg::TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ecfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (i_s_tuser),
        .i_byte  (i_s_tdata),
        .o_push  (push),
        .o_token (front_token),
        .i_full  (full)
    );

    ecfr_fifo #(
        .DEPTH (ecfr_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (tok_valid),
        .o_token (queue_token)
    );

    ecfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_length   (r_max_length),
        .i_byte_timeout (r_byte_timeout),
        .i_tok_valid    (tok_valid),
        .i_token        (queue_token),
        .o_pop          (pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_result       (result)
    );

    assign o_m_tuser = result.kind;
    assign o_m_tdata = {2'b00, result.frame_length, result.frame_type,
                        result.status, result.payload_byte};

endmodule

// File: rtl/ecfr_checker.sv
// Port-level checker for the escaped CRC frame receiver, bound to its top level.
// Depends on ecfr_pkg and on the port list of escaped_crc_frame_receiver_top.
module ecfr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_tvalid,
    input logic                                 o_s_tready,
    input logic [ecfr_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input logic                                 i_s_tuser,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [ecfr_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input logic                                 o_m_tuser,
    input logic                                 i_cfg_we,
    input logic [ecfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [ecfr_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [2:0] st;
    assign st = o_m_tdata[10:8];

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // A payload beat carries only its byte.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ecfr_pkg::KIND_PAYLOAD) |-> o_m_tdata[31:8] == '0)
        else $error("payload beat carries status fields");

    // A status beat has a defined code, no payload byte, and a length only when ok.
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ecfr_pkg::KIND_STATUS) |->
            (st == ecfr_pkg::ST_OK || st == ecfr_pkg::ST_TIMEOUT || st == ecfr_pkg::ST_FRAME ||
             st == ecfr_pkg::ST_OVERFLOW || st == ecfr_pkg::ST_CRC) &&
            o_m_tdata[7:0] == '0 && (st == ecfr_pkg::ST_OK || o_m_tdata[29:19] == '0))
        else $error("malformed status beat");

    // Type is reported only on ok or CRC-error ends.
    a_type_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ecfr_pkg::KIND_STATUS) &&
            st != ecfr_pkg::ST_OK && st != ecfr_pkg::ST_CRC |-> o_m_tdata[18:11] == '0)
        else $error("type reported on an error end");

endmodule

bind escaped_crc_frame_receiver_top ecfr_checker u_ecfr_checker (.*);
